>>> hw/rtl/rtcsp_pkg.sv
`timescale 1ns / 1ps

package rtcsp_pkg;

	localparam int SNAP_W = 56;

	localparam logic [3:0] CMD_MAGIC    = 4'h6;
	localparam logic [7:0] CTRL_RESET   = 8'h40;
	localparam logic [7:0] HOUR_MASK    = 8'h3F;
	localparam int         CMD_READ_BIT = 7;

	// command selector, bits 6..4 of the command byte
	localparam logic [2:0] SEL_RESET    = 3'd0;
	localparam logic [2:0] SEL_DATETIME = 3'd2;
	localparam logic [2:0] SEL_CONTROL  = 3'd4;
	localparam logic [2:0] SEL_TIME     = 3'd6;

	localparam logic [2:0] LEN_DATETIME = 3'd7;
	localparam logic [2:0] LEN_CONTROL  = 3'd1;
	localparam logic [2:0] LEN_TIME     = 3'd3;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_CLK_SEEN = 2'd1,
		PH_OPEN     = 2'd2
	} phase_t;

endpackage

>>> hw/rtl/rtcsp_wr_if.sv
`timescale 1ns / 1ps

interface rtcsp_wr_if;
	logic                        valid;
	logic                        ready;
	logic [3:0]                  pins_in;
	logic [3:0]                  direction;
	logic [rtcsp_pkg::SNAP_W-1:0] clock_snapshot;

	modport source (output valid, pins_in, direction, clock_snapshot, input ready);
	modport sink (input valid, pins_in, direction, clock_snapshot, output ready);
endinterface

>>> hw/rtl/rtcsp_res_if.sv
`timescale 1ns / 1ps

interface rtcsp_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] pins_out;
	logic       pins_changed;

	modport source (output valid, pins_out, pins_changed, input ready);
	modport sink (input valid, pins_out, pins_changed, output ready);
endinterface

>>> hw/rtl/cartridge_rtc_serial_port.sv
// Serial RTC chip behind a cartridge GPIO port, one pin write per item.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle; the result register is the only stage, and
// a new item is taken whenever that register is empty or being drained.
// Reset (arst_n low, asynchronous): transfer idle, counters and command cleared,
// control byte 0x40, no result pending. The time latch is not reset.
`timescale 1ns / 1ps

module cartridge_rtc_serial_port (
	input logic        clk,
	input logic        arst_n,
	rtcsp_wr_if.sink   pins,
	rtcsp_res_if.source result
);
	import rtcsp_pkg::*;

	phase_t                phase_q, phase_d;
	logic [7:0]            shift_q, shift_d;
	logic [2:0]            bit_q, bit_d;
	logic [7:0]            cmd_q, cmd_d;
	logic                  active_q, active_d;
	logic [2:0]            left_q, left_d;
	logic [7:0]            ctrl_q, ctrl_d;
	logic [SNAP_W-1:0]     latch_q;
	logic [SNAP_W-1:0]     latch_val;
	logic                  latch_en;

	logic                  out_valid_q;
	logic [3:0]            pins_out_q;
	logic                  changed_q;
	logic [3:0]            po;
	logic                  chg;

	logic                  acc;
	logic [3:0]            pin_v;
	logic [3:0]            dir_v;
	logic [2:0]            sel;
	logic [2:0]            tx_idx;
	logic [7:0]            tx_byte;
	logic                  tx_bit;
	logic [2:0]            left_tmp;

	assign pins.ready = !out_valid_q || result.ready;
	assign acc        = pins.valid && pins.ready;
	assign pin_v      = pins.pins_in;
	assign dir_v      = pins.direction;
	assign sel        = cmd_q[6:4];

	// hours byte (byte 4) is masked on latch
	assign latch_val = {pins.clock_snapshot[55:40],
		pins.clock_snapshot[39:32] & HOUR_MASK, pins.clock_snapshot[31:0]};

	// bit presented on a read edge
	always_comb begin
		tx_idx  = 3'(3'd7 - left_q);
		tx_byte = 8'h00;
		if (sel == SEL_DATETIME || sel == SEL_TIME) begin
			if (tx_idx != 3'd7) begin
				tx_byte = latch_q[{tx_idx, 3'b000} +: 8];
			end
		end else if (sel == SEL_CONTROL) begin
			tx_byte = ctrl_q;
		end
		tx_bit = active_q && tx_byte[bit_q];
	end

	always_comb begin
		phase_d  = phase_q;
		shift_d  = shift_q;
		bit_d    = bit_q;
		cmd_d    = cmd_q;
		active_d = active_q;
		left_d   = left_q;
		ctrl_d   = ctrl_q;
		latch_en = 1'b0;
		left_tmp = left_q;
		po       = pin_v;
		chg      = 1'b0;
		unique case (phase_q)
			PH_CLK_SEEN: begin
				if (pin_v[0] && pin_v[2]) begin
					phase_d = PH_OPEN;
				end else if (!(pin_v[0] && !pin_v[2])) begin
					phase_d = PH_IDLE;
				end
			end
			PH_OPEN: begin
				if (!pin_v[0]) begin
					shift_d[bit_q] = pin_v[1];
				end else if (pin_v[2]) begin
					if (cmd_q[CMD_READ_BIT]) begin
						po  = (pin_v & dir_v) | ({2'b01, tx_bit, 1'b1} & ~dir_v);
						chg = 1'b1;
						bit_d = bit_q + 3'd1;
						if (bit_q == 3'd7) begin
							if (left_q != 3'd0) begin
								left_tmp = left_q - 3'd1;
							end
							left_d = left_tmp;
							if (left_tmp == 3'd0) begin
								active_d = 1'b0;
								cmd_d    = 8'h00;
							end
						end
					end else begin
						bit_d = bit_q + 3'd1;
						if (bit_q == 3'd7) begin
							// full byte received
							if (!active_q) begin
								if (shift_q[3:0] == CMD_MAGIC) begin
									cmd_d = shift_q;
									case (shift_q[6:4])
										SEL_RESET: begin
											ctrl_d   = 8'h00;
											left_tmp = 3'd0;
										end
										SEL_DATETIME: begin
											latch_en = 1'b1;
											left_tmp = LEN_DATETIME;
										end
										SEL_CONTROL: left_tmp = LEN_CONTROL;
										SEL_TIME: begin
											latch_en = 1'b1;
											left_tmp = LEN_TIME;
										end
										default: left_tmp = 3'd0;
									endcase
									active_d = left_tmp != 3'd0;
								end
							end else begin
								if (left_q != 3'd0) begin
									left_tmp = left_q - 3'd1;
								end
								if (sel == SEL_CONTROL) begin
									ctrl_d = shift_q;
								end
							end
							left_d  = left_tmp;
							shift_d = 8'h00;
							bit_d   = 3'd0;
							if (left_tmp == 3'd0) begin
								active_d = 1'b0;
								cmd_d    = 8'h00;
							end
						end
					end
				end else begin
					// select dropped with clock high: abort
					shift_d  = 8'h00;
					bit_d    = 3'd0;
					active_d = 1'b0;
					cmd_d    = 8'h00;
					left_d   = 3'd0;
					phase_d  = PH_CLK_SEEN;
					po       = (pin_v & dir_v) | (4'b0001 & ~dir_v);
					chg      = 1'b1;
				end
			end
			default: begin
				phase_d = (pin_v[0] && !pin_v[2]) ? PH_CLK_SEEN : PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= 8'h00;
			bit_q       <= 3'd0;
			cmd_q       <= 8'h00;
			active_q    <= 1'b0;
			left_q      <= 3'd0;
			ctrl_q      <= CTRL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				phase_q  <= phase_d;
				shift_q  <= shift_d;
				bit_q    <= bit_d;
				cmd_q    <= cmd_d;
				active_q <= active_d;
				left_q   <= left_d;
				ctrl_q   <= ctrl_d;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pins_out_q <= po;
			changed_q  <= chg;
			if (latch_en) begin
				latch_q <= latch_val;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.pins_out     = pins_out_q;
	assign result.pins_changed = changed_q;

endmodule

>>> hw/rtl/rtcsp_checker.sv
`timescale 1ns / 1ps

module rtcsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [3:0] in_pins,
	input logic [3:0] in_dir,
	input logic       res_valid,
	input logic       res_ready,
	input logic [3:0] res_pins,
	input logic       res_changed
);

	// result held until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// every accepted item shows its result in the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> res_valid)
		else $error("accepted item produced no result");

	// without chip drive the pins come back unchanged
	a_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> res_changed || res_pins == $past(in_pins))
		else $error("pins altered without chip drive");

	// host-driven pins are never overridden
	a_host_pins: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ((res_pins ^ $past(in_pins)) & $past(in_dir)) == 4'h0)
		else $error("host-driven pin overridden");

	// an empty result register never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind cartridge_rtc_serial_port rtcsp_checker u_rtcsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pins.valid),
	.in_ready    (pins.ready),
	.in_pins     (pins.pins_in),
	.in_dir      (pins.direction),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_pins    (result.pins_out),
	.res_changed (result.pins_changed)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rtcsp_pkg::*;

	localparam int RAND_ITEMS     = 580;
	localparam int DIRECTED_COUNT = 23;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int LONG_HOLD      = 120;
	localparam int TAIL_CYCLES    = 8;
	localparam int HOLD_AT_ITEM   = 250;
	localparam int PAUSE_AT_ITEM  = 400;

	// GPIO pin positions
	localparam int PIN_SCK = 0;
	localparam int PIN_SIO = 1;
	localparam int PIN_CS  = 2;

	typedef struct packed {
		logic [3:0] pins_out;
		logic       changed;
	} pin_result_t;

	typedef struct {
		logic        typed;
		pin_result_t val;
	} row_note_t;

	typedef struct packed {
		logic [3:0] pins;
		logic [3:0] dir;
		logic       typed;
		logic [3:0] po;
		logic       ch;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rtcsp_wr_if  wr_ch ();
	rtcsp_res_if res_ch ();

	cartridge_rtc_serial_port u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pins   (wr_ch),
		.result (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// directed rows: open a transfer, shift in the reset command (0x06), abort
	stim_row_t directed_rows [DIRECTED_COUNT] = '{
		'{4'h0, 4'hF, 1'b1, 4'h0, 1'b0},
		'{4'hF, 4'h0, 1'b1, 4'hF, 1'b0},
		'{4'h1, 4'hF, 1'b1, 4'h1, 1'b0},
		'{4'h5, 4'hF, 1'b1, 4'h5, 1'b0},
		'{4'h4, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h5, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h6, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h7, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h6, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h7, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h4, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h5, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h4, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h5, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h4, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h5, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h4, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h5, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h4, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h5, 4'hD, 1'b0, 4'h0, 1'b0},
		'{4'h1, 4'hA, 1'b1, 4'h1, 1'b1},
		'{4'h0, 4'hF, 1'b1, 4'h0, 1'b0},
		'{4'h8, 4'hF, 1'b1, 4'h8, 1'b0}
	};

	// chip state as seen by the predictor
	phase_t      rtc_phase  = PH_IDLE;
	logic [7:0]  rtc_shift  = 8'h00;
	logic [2:0]  rtc_bit    = 3'd0;
	logic [7:0]  rtc_cmd    = 8'h00;
	logic        rtc_active = 1'b0;
	logic [2:0]  rtc_left   = 3'd0;
	logic [7:0]  rtc_ctrl   = CTRL_RESET;
	logic [55:0] rtc_latch  = '0;

	pin_result_t pending_pins [$];
	row_note_t   row_notes [$];
	row_note_t   cur_note;

	int   mismatches = 0;
	int   n_checked = 0;
	int   n_items = 0;
	int   n_transfers = 0;
	int   n_aborts = 0;
	int   n_reads = 0;
	int   sel_count [8];
	int   cycle_count = 0;
	logic hold_req = 1'b0;

	function automatic logic [55:0] hour_masked(input logic [55:0] snap);
		logic [55:0] t;
		t = snap;
		t[39:32] = snap[39:32] & HOUR_MASK;
		return t;
	endfunction

	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 65)
			return 0;
		if (r < 93)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 30));
	endfunction

	function automatic logic [55:0] rand_snap();
		return 56'({$urandom(), $urandom()});
	endfunction

	function automatic logic [3:0] pick_dir();
		logic [3:0] d;
		case ($urandom_range(0, 3))
			0: d = 4'hF;
			1: d = 4'hD;
			2: d = 4'h9;
			default: d = 4'($urandom_range(0, 15));
		endcase
		return d;
	endfunction

	// bit the chip presents on a read edge
	function automatic logic out_bit();
		logic [7:0] b;
		logic [2:0] idx;
		b = 8'h00;
		idx = 3'(3'd7 - rtc_left);
		if (!rtc_active)
			return 1'b0;
		if (rtc_cmd[6:4] == SEL_DATETIME || rtc_cmd[6:4] == SEL_TIME) begin
			if (idx != 3'd7)
				b = rtc_latch[{idx, 3'b000} +: 8];
		end else if (rtc_cmd[6:4] == SEL_CONTROL) begin
			b = rtc_ctrl;
		end
		return b[rtc_bit];
	endfunction

	task automatic finish_byte(input logic [55:0] snap);
		if (!rtc_active) begin
			if (rtc_shift[3:0] == CMD_MAGIC) begin
				rtc_cmd = rtc_shift;
				sel_count[rtc_shift[6:4]]++;
				case (rtc_shift[6:4])
					SEL_RESET: begin
						rtc_ctrl = 8'h00;
						rtc_left = 3'd0;
					end
					SEL_DATETIME: begin
						rtc_latch = hour_masked(snap);
						rtc_left = LEN_DATETIME;
					end
					SEL_CONTROL: rtc_left = LEN_CONTROL;
					SEL_TIME: begin
						rtc_latch = hour_masked(snap);
						rtc_left = LEN_TIME;
					end
					default: rtc_left = 3'd0;
				endcase
				rtc_active = (rtc_left != 3'd0);
			end
		end else begin
			if (rtc_left != 3'd0)
				rtc_left = rtc_left - 3'd1;
			if (rtc_cmd[6:4] == SEL_CONTROL)
				rtc_ctrl = rtc_shift;
		end
		rtc_shift = 8'h00;
		rtc_bit = 3'd0;
		if (rtc_left == 3'd0) begin
			rtc_active = 1'b0;
			rtc_cmd = 8'h00;
		end
	endtask

	task automatic predict(input logic [3:0] p, input logic [3:0] d,
		input logic [55:0] snap, output pin_result_t r);
		logic ob;
		r.pins_out = p;
		r.changed = 1'b0;
		case (rtc_phase)
			PH_CLK_SEEN: begin
				if (p[PIN_SCK] && p[PIN_CS]) begin
					rtc_phase = PH_OPEN;
					n_transfers++;
				end else if (!(p[PIN_SCK] && !p[PIN_CS])) begin
					rtc_phase = PH_IDLE;
				end
			end
			PH_OPEN: begin
				if (!p[PIN_SCK]) begin
					rtc_shift[rtc_bit] = p[PIN_SIO];
				end else if (p[PIN_CS]) begin
					if (rtc_cmd[CMD_READ_BIT]) begin
						ob = out_bit();
						r.pins_out = (p & d) | ((4'h5 | {2'b00, ob, 1'b0}) & ~d);
						r.changed = 1'b1;
						n_reads++;
						if (rtc_bit == 3'd7) begin
							rtc_bit = 3'd0;
							if (rtc_left != 3'd0)
								rtc_left = rtc_left - 3'd1;
							if (rtc_left == 3'd0) begin
								rtc_active = 1'b0;
								rtc_cmd = 8'h00;
							end
						end else begin
							rtc_bit = rtc_bit + 3'd1;
						end
					end else if (rtc_bit == 3'd7) begin
						finish_byte(snap);
					end else begin
						rtc_bit = rtc_bit + 3'd1;
					end
				end else begin
					// select dropped with clock high
					rtc_shift = 8'h00;
					rtc_bit = 3'd0;
					rtc_active = 1'b0;
					rtc_cmd = 8'h00;
					rtc_left = 3'd0;
					rtc_phase = PH_CLK_SEEN;
					r.pins_out = (p & d) | (4'h1 & ~d);
					r.changed = 1'b1;
					n_aborts++;
				end
			end
			default: rtc_phase = (p[PIN_SCK] && !p[PIN_CS]) ? PH_CLK_SEEN : PH_IDLE;
		endcase
	endtask

	// offer one item at a falling edge and hold it until taken
	task automatic send_item(input logic [3:0] p, input logic [3:0] d,
		input logic [55:0] s, input row_note_t note);
		int gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
		cur_note = note;
		wr_ch.valid = 1'b1;
		wr_ch.pins_in = p;
		wr_ch.direction = d;
		wr_ch.clock_snapshot = s;
		@(posedge clk);
		while (!wr_ch.ready)
			@(posedge clk);
		@(negedge clk);
		wr_ch.valid = 1'b0;
	endtask

	task automatic send(input logic [3:0] p, input logic [3:0] d, input logic [55:0] s);
		row_note_t note;
		note.typed = 1'b0;
		note.val = '0;
		send_item(p, d, s, note);
	endtask

	// data on the low half of the clock, then the rising edge
	task automatic send_byte(input logic [7:0] b, input logic [3:0] d,
		input logic [55:0] s, input int nbits);
		int i;
		for (i = 0; i < nbits; i++) begin
			send({1'($urandom_range(0, 1)), 1'b1, b[i], 1'b0}, d, s);
			send({1'($urandom_range(0, 1)), 1'b1, b[i], 1'b1}, d, s);
		end
	endtask

	task automatic run_transfer();
		logic [7:0]  cmd;
		logic [3:0]  d;
		logic [55:0] s;
		int          nbytes;
		int          k;
		d = pick_dir();
		s = rand_snap();
		send(4'h1, d, s);
		send(4'h5, d, s);
		cmd[7] = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 4))
			0: cmd[6:4] = SEL_DATETIME;
			1: cmd[6:4] = SEL_CONTROL;
			2: cmd[6:4] = SEL_TIME;
			3: cmd[6:4] = SEL_RESET;
			default: cmd[6:4] = 3'($urandom_range(0, 7));
		endcase
		cmd[3:0] = ($urandom_range(0, 9) < 8) ? CMD_MAGIC : 4'($urandom_range(0, 15));
		send_byte(cmd, d, s, 8);
		nbytes = ($urandom_range(0, 5) == 0) ? 7 : int'($urandom_range(0, 3));
		for (k = 0; k < nbytes; k++)
			send_byte(8'($urandom_range(0, 255)), d, s, 8);
		case ($urandom_range(0, 3))
			0: begin
				send(4'h1, d, s);
				send(4'h0, d, s);
			end
			1: send(4'h0, d, s);
			2: begin
				// cut a byte short
				send_byte(8'($urandom_range(0, 255)), d, s, int'($urandom_range(1, 7)));
				send(4'h1, d, s);
			end
			default: ;
		endcase
	endtask

	task automatic run_noise();
		int k;
		int n;
		n = int'($urandom_range(1, 6));
		for (k = 0; k < n; k++)
			send(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), rand_snap());
	endtask

	always @(posedge clk) begin : in_mon
		pin_result_t exp_r;
		if (arst_n && wr_ch.valid && wr_ch.ready) begin
			predict(wr_ch.pins_in, wr_ch.direction, wr_ch.clock_snapshot, exp_r);
			pending_pins.push_back(exp_r);
			row_notes.push_back(cur_note);
			n_items++;
		end
	end

	always @(posedge clk) begin : out_mon
		pin_result_t got;
		pin_result_t exp_r;
		row_note_t   note;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.pins_out = res_ch.pins_out;
			got.changed = res_ch.pins_changed;
			if (pending_pins.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item, expected none, got pins %h changed %b",
					$time, got.pins_out, got.changed);
			end else begin
				exp_r = pending_pins.pop_front();
				note = row_notes.pop_front();
				n_checked++;
				if (got !== exp_r) begin
					mismatches++;
					$display("%0t: expected pins %h changed %b, got pins %h changed %b",
						$time, exp_r.pins_out, exp_r.changed, got.pins_out, got.changed);
				end
				if (note.typed && got !== note.val) begin
					mismatches++;
					$display("%0t: table row expected pins %h changed %b, got pins %h changed %b",
						$time, note.val.pins_out, note.val.changed, got.pins_out, got.changed);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results outstanding",
				$time, pending_pins.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : receiver
		int idle;
		idle = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready = 1'b0;
			end else if (idle > 0) begin
				res_ch.ready = 1'b0;
				idle--;
			end else begin
				res_ch.ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					idle = pick_gap();
			end
		end
	end

	// long output stall while the sender keeps offering
	initial begin : long_hold
		wait (n_items >= HOLD_AT_ITEM);
		@(negedge clk);
		hold_req = 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		hold_req = 1'b0;
	end

	initial begin : main
		int        i;
		logic      paused;
		row_note_t note;
		wr_ch.valid = 1'b0;
		wr_ch.pins_in = 4'h0;
		wr_ch.direction = 4'h0;
		wr_ch.clock_snapshot = '0;
		cur_note.typed = 1'b0;
		cur_note.val = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < DIRECTED_COUNT; i++) begin
			note.typed = directed_rows[i].typed;
			note.val.pins_out = directed_rows[i].po;
			note.val.changed = directed_rows[i].ch;
			send_item(directed_rows[i].pins, directed_rows[i].dir, rand_snap(), note);
		end
		wait (pending_pins.size() == 0);
		@(negedge clk);

		paused = 1'b0;
		while (n_items < DIRECTED_COUNT + RAND_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				run_noise();
			else
				run_transfer();
			if (!paused && n_items >= PAUSE_AT_ITEM) begin
				wait (pending_pins.size() == 0);
				@(negedge clk);
				paused = 1'b1;
			end
		end

		wait (pending_pins.size() == 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Ran %0d items (%0d checked) over %0d transfers, %0d aborts, %0d read edges",
			n_items, n_checked, n_transfers, n_aborts, n_reads);
		$display("Commands seen: reset %0d, date-time %0d, control %0d, time %0d; "
			, sel_count[SEL_RESET], sel_count[SEL_DATETIME], sel_count[SEL_CONTROL],
			sel_count[SEL_TIME], "with a long output stall and a full drain pause");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/rtcsp_pkg.sv
hw/rtl/rtcsp_wr_if.sv
hw/rtl/rtcsp_res_if.sv
hw/rtl/cartridge_rtc_serial_port.sv
hw/rtl/rtcsp_checker.sv
tb/tb_top.sv
